/* hdl/cmmta_pkg.sv */
// Package for the channel min/max/trend/average monitor.
// Holds payload structs, action codes, sizes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cmmta_pkg;

    localparam int NumChannels = 20;
    localparam int WindowDepth = 1440;
    localparam int SlotW = 11;
    localparam int SumW = 19;
    localparam int RingDepth = NumChannels * WindowDepth;
    localparam int RingAw = 15;

    localparam logic [2:0] ActSample = 3'd0;
    localparam logic [2:0] ActRead = 3'd1;
    localparam logic [2:0] ActResetMinMax = 3'd2;
    localparam logic [2:0] ActSnapshot = 3'd3;
    localparam logic [2:0] ActRestart = 3'd4;

    localparam logic [1:0] TrendSteady = 2'd0;
    localparam logic [1:0] TrendRising = 2'd1;
    localparam logic [1:0] TrendFalling = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] channel;
        logic [7:0] sample_code;
        logic       round_end;
    } t_in_item;

    typedef struct packed {
        logic [4:0] out_channel;
        logic [7:0] current_value;
        logic [1:0] trend_flag;
        logic [7:0] minimum_value;
        logic [7:0] maximum_value;
        logic [7:0] snapshot_value;
        logic [7:0] average_value;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input item, start ring read
        logic update;     // apply sample/all-channel action, start divide
        logic div_step;   // one restoring-divide step
        logic emit;       // build result into output register
    } t_cmd;

    typedef struct packed {
        logic is_sample;  // valid in-range sample needs divide
        logic div_last;   // final divide step this cycle
    } t_status;

endpackage
`default_nettype wire

/* hdl/channel_min_max_trend_average.sv */
// Multichannel min/max/trend/moving-average monitor for 8-bit sensor codes.
// Input channel (i_in_valid/o_in_ready, i_in_item) takes one action per
// transfer: sample, read channel, reset min/max, snapshot all, restart
// average. Every action yields exactly one result on the output channel
// (o_out_valid/i_out_ready, o_out_item).
// After an input transfer the controller steps through READ, UPDATE and
// EMIT before the result is valid; an in-range sample also passes through
// DIV, where the bit-serial divider forms the window average. One item is
// in work at a time; the next input transfer is taken the cycle after the
// result is loaded.
// The result sits in an output register; if the receiver stalls, the next
// item is still taken and processed, and waits before its emit cycle.
// i_cfg_we/i_cfg_data write trend_margin (reset 1) at any clock edge outside reset.
// Synchronous active-low reset clears all channel stores (minimum to FF), slot and fill
// count; the history ring is not cleared, the fill count guards it.
`timescale 1ns / 1ps
`default_nettype none
module channel_min_max_trend_average (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [7:0]            i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  cmmta_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output cmmta_pkg::t_out_item  o_out_item
);
    cmmta_pkg::t_cmd    w_cmd;
    cmmta_pkg::t_status w_status;

    cmmta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cmmta_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_item     (o_out_item)
    );
endmodule
`default_nettype wire

/* hdl/cmmta_ctrl.sv */
// Controller state machine for the monitor.
// Depends on cmmta_pkg; drives the datapath through t_cmd.
`timescale 1ns / 1ps
`default_nettype none
module cmmta_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    input  cmmta_pkg::t_status   i_status,
    output cmmta_pkg::t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_UPDATE, S_DIV, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    // Emit waits only if the output register still holds an untaken result.
    wire w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_UPDATE;
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = i_status.is_sample ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

/* hdl/cmmta_dp.sv */
// Datapath for the monitor: channel stores, history ring memory,
// window sums and a restoring divider. Depends on cmmta_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmmta_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [7:0]            i_cfg_data,
    input  cmmta_pkg::t_in_item   i_item,
    input  cmmta_pkg::t_cmd       i_cmd,
    output cmmta_pkg::t_status    o_status,
    output cmmta_pkg::t_out_item  o_item
);
    localparam int N = cmmta_pkg::NumChannels;
    localparam int SW = cmmta_pkg::SumW;
    localparam int LW = cmmta_pkg::SlotW;
    localparam int DivCntW = 5;

    logic [7:0] r_margin;
    logic [7:0] r_cur [N];
    logic [7:0] r_min [N];
    logic [7:0] r_max [N];
    logic [7:0] r_snap [N];
    logic [1:0] r_trend [N];
    logic [7:0] r_avg [N];
    logic [SW-1:0] r_sum [N];
    logic [LW-1:0] r_slot, r_filled;

    logic [7:0] r_ring [cmmta_pkg::RingDepth];
    logic [7:0] r_ring_q;

    cmmta_pkg::t_in_item r_item;
    logic [cmmta_pkg::RingAw-1:0] r_addr;

    // Divider state
    logic [SW-1:0] r_quo;     // dividend shifting into quotient
    logic [LW:0]   r_rem;
    logic [LW:0]   r_den;
    logic [DivCntW-1:0] r_cnt;
    logic [4:0]    r_div_ch;

    cmmta_pkg::t_out_item r_out;

    wire w_in_range = r_item.channel < 5'(N);
    wire w_is_sample = r_item.action == cmmta_pkg::ActSample;
    wire w_is_read = r_item.action == cmmta_pkg::ActRead;
    wire w_ch_action = w_is_sample || w_is_read;
    wire [4:0] w_ch = r_item.channel;
    wire [4:0] w_view_ch = w_ch_action ? w_ch : 5'd0;
    wire [7:0] w_code = r_item.sample_code;
    wire w_filled = r_slot < r_filled;

    wire [cmmta_pkg::RingAw-1:0] w_addr =
        cmmta_pkg::RingAw'(i_item.channel) * cmmta_pkg::RingAw'(cmmta_pkg::WindowDepth)
        + cmmta_pkg::RingAw'(r_slot);

    wire [SW-1:0] w_sum_old = w_filled ? r_sum[w_ch] - SW'(r_ring_q) : r_sum[w_ch];
    wire [SW-1:0] w_sum_new = w_sum_old + SW'(w_code);
    wire [LW:0] w_count = w_filled ? {1'b0, r_filled} : {1'b0, r_filled} + 1'b1;

    wire [8:0] w_prev_m = {1'b0, r_cur[w_ch]} + {1'b0, r_margin};
    wire [8:0] w_code_m = {1'b0, w_code} + {1'b0, r_margin};

    // Divider step: shift in next dividend bit, subtract if it fits
    wire [LW+1:0] w_trial = {r_rem, r_quo[SW-1]};
    wire w_fits = w_trial >= {1'b0, r_den};
    wire [LW+1:0] w_diff = w_trial - {1'b0, r_den};

    assign o_status.is_sample = w_is_sample && w_in_range;
    assign o_status.div_last = r_cnt == DivCntW'(SW - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_addr <= w_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ring_q <= r_ring[r_addr];
        if (i_cmd.update && w_is_sample && w_in_range)
            r_ring[r_addr] <= w_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= 8'd1;
            r_slot <= '0;
            r_filled <= '0;
            for (int i = 0; i < N; i++) begin
                r_cur[i] <= '0;
                r_min[i] <= 8'hFF;
                r_max[i] <= '0;
                r_snap[i] <= '0;
                r_trend[i] <= cmmta_pkg::TrendSteady;
                r_avg[i] <= '0;
                r_sum[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_margin <= i_cfg_data;
            if (i_cmd.update) begin
                if (w_is_sample) begin
                    if (w_in_range) begin
                        r_cur[w_ch] <= w_code;
                        if (w_code < r_min[w_ch]) r_min[w_ch] <= w_code;
                        if (w_code > r_max[w_ch]) r_max[w_ch] <= w_code;
                        if ({1'b0, w_code} > w_prev_m)
                            r_trend[w_ch] <= cmmta_pkg::TrendRising;
                        else if (w_code_m < {1'b0, r_cur[w_ch]})
                            r_trend[w_ch] <= cmmta_pkg::TrendFalling;
                        else
                            r_trend[w_ch] <= cmmta_pkg::TrendSteady;
                        r_sum[w_ch] <= w_sum_new;
                    end
                    if (r_item.round_end) begin
                        r_slot <= (r_slot == LW'(cmmta_pkg::WindowDepth - 1))
                                  ? '0 : r_slot + 1'b1;
                        if (r_filled < LW'(cmmta_pkg::WindowDepth))
                            r_filled <= r_filled + 1'b1;
                    end
                end else if (r_item.action == cmmta_pkg::ActResetMinMax) begin
                    for (int i = 0; i < N; i++) begin
                        r_min[i] <= r_cur[i];
                        r_max[i] <= r_cur[i];
                    end
                end else if (r_item.action == cmmta_pkg::ActSnapshot) begin
                    for (int i = 0; i < N; i++) r_snap[i] <= r_cur[i];
                end else if (r_item.action == cmmta_pkg::ActRestart) begin
                    r_slot <= '0;
                    r_filled <= '0;
                    for (int i = 0; i < N; i++) r_sum[i] <= '0;
                end
            end
            // Saturate quotient into the stored average on the last step
            if (i_cmd.div_step && o_status.div_last) begin
                r_avg[r_div_ch] <= |r_quo[SW-2:7] ? 8'hFF : {r_quo[6:0], w_fits};
            end
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_quo <= w_sum_new;
            r_rem <= '0;
            r_den <= w_count;
            r_cnt <= '0;
            r_div_ch <= w_ch;
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? w_diff[LW:0] : w_trial[LW:0];
            r_quo <= {r_quo[SW-2:0], w_fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_channel <= w_view_ch;
            if (w_ch_action && !w_in_range) begin
                r_out.current_value <= '0;
                r_out.trend_flag <= cmmta_pkg::TrendSteady;
                r_out.minimum_value <= '0;
                r_out.maximum_value <= '0;
                r_out.snapshot_value <= '0;
                r_out.average_value <= '0;
            end else begin
                r_out.current_value <= r_cur[w_view_ch];
                r_out.trend_flag <= r_trend[w_view_ch];
                r_out.minimum_value <= r_min[w_view_ch];
                r_out.maximum_value <= r_max[w_view_ch];
                r_out.snapshot_value <= r_snap[w_view_ch];
                r_out.average_value <= r_avg[w_view_ch];
            end
        end
    end

    assign o_item = r_out;
endmodule
`default_nettype wire
